### hdl/sync_frame_receiver_checksum_top_defines.svh
// Assertion macros for the sync frame receiver.
// Included by sync_frame_receiver_checksum_top; no other dependencies.
`ifndef SYNC_FRAME_RECEIVER_CHECKSUM_TOP_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CHECKSUM_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfrc assertion failed");

// next-cycle implication, disabled during reset
`define SFRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfrc assertion failed");

`endif

### hdl/sfrc_pkg.sv
// Shared types and constants of the sync frame receiver.
// No dependencies.
`default_nettype none

package sfrc_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_FUNC    = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} sfrc_phase_t;

	typedef enum logic [1:0] {
		ST_RX = 2'd0,
		ST_RD = 2'd1,
		ST_LD = 2'd2
	} sfrc_state_t;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [8:0] function_limit;
		logic [6:0] length_limit;
	} sfrc_cfg_t;

	typedef struct packed {
		logic take_byte;
		logic load_err;
		logic rd_clear;
		logic load_pay;
	} sfrc_cmd_t;

	typedef struct packed {
		logic at_check;
		logic sum_match;
		logic slot_busy;
		logic idx_last;
	} sfrc_stat_t;

	localparam logic [1:0] REG_SYNC_BYTE      = 2'd0;
	localparam logic [1:0] REG_FUNCTION_LIMIT = 2'd1;
	localparam logic [1:0] REG_LENGTH_LIMIT   = 2'd2;

	localparam logic [7:0] SYNC_BYTE_RST      = 8'hAA;
	localparam logic [8:0] FUNCTION_LIMIT_RST = 9'd241;
	localparam logic [6:0] LENGTH_LIMIT_RST   = 7'd50;

endpackage

`default_nettype wire

### hdl/sfrc_if.sv
// Channel interfaces of the sync frame receiver: link bytes in, results out.
// No dependencies.
`default_nettype none

interface sfrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrc_result_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] function_code;
	logic [5:0] payload_length;
	logic [5:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output status, output function_code, output payload_length,
		output byte_index, output payload_byte, output last, input ready);
	modport sink (input valid, input status, input function_code, input payload_length,
		input byte_index, input payload_byte, input last, output ready);
endinterface

`default_nettype wire

### hdl/sfrc_ctrl.sv
// Controller FSM: byte intake, then read-and-load sequencing of the payload run.
// Depends on sfrc_pkg.
`default_nettype none

module sfrc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sfrc_pkg::sfrc_stat_t stat,
	output sfrc_pkg::sfrc_cmd_t    cmd
);
	import sfrc_pkg::*;

	sfrc_state_t state_q, state_d;
	logic        take;

	// checksum byte needs the output slot free (or freeing this cycle)
	assign in_ready = (state_q == ST_RX) && !(stat.at_check && stat.slot_busy);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RX: begin
				if (take && stat.at_check && stat.sum_match) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_LD;
			end
			ST_LD: begin
				if (!stat.slot_busy) begin
					state_d = stat.idx_last ? ST_RX : ST_RD;
				end
			end
			default: state_d = ST_RX;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_RX: begin
				cmd.take_byte = take;
				cmd.load_err  = take && stat.at_check && !stat.sum_match;
				cmd.rd_clear  = take && stat.at_check && stat.sum_match;
			end
			ST_RD: begin
			end
			ST_LD: begin
				cmd.load_pay = !stat.slot_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/sfrc_dp.sv
// Datapath: frame parser registers, running checksum, payload store, output register.
// Depends on sfrc_pkg and sfrc_if.
`default_nettype none

module sfrc_dp #(
	parameter int STORE_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfrc_pkg::sfrc_cfg_t  cfg,
	input  wire logic [7:0]           rx_byte,
	input  wire sfrc_pkg::sfrc_cmd_t  cmd,
	output sfrc_pkg::sfrc_stat_t      stat,
	sfrc_result_if.source             frame
);
	import sfrc_pkg::*;

	localparam int         AW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [8:0] DEPTH_LIM = 9'(STORE_DEPTH);

	sfrc_phase_t phase_q, phase_d;
	logic [5:0]  rem_q, rem_d;
	logic [5:0]  stored_q, stored_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  func_q, func_d;
	logic [5:0]  len_q, len_d;
	logic        wr_en;
	logic        len_ok;

	logic [7:0]  store_mem [STORE_DEPTH];
	logic [7:0]  rdata_q;
	logic [5:0]  idx_q;

	logic        out_valid_q;
	logic        out_status_q;
	logic [7:0]  out_func_q;
	logic [5:0]  out_len_q;
	logic [5:0]  out_idx_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	// length must clear both the register limit and the store depth
	assign len_ok = ({1'b0, rx_byte} < {2'b00, cfg.length_limit}) && ({1'b0, rx_byte} < DEPTH_LIM);

	always_comb begin
		phase_d  = phase_q;
		rem_d    = rem_q;
		stored_d = stored_q;
		sum_d    = sum_q;
		func_d   = func_q;
		len_d    = len_q;
		wr_en    = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.sync_byte) begin
					phase_d = PH_SYNC2;
					sum_d   = rx_byte;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == cfg.sync_byte) begin
					phase_d = PH_FUNC;
					sum_d   = sum_q + rx_byte;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_FUNC: begin
				if ({1'b0, rx_byte} < cfg.function_limit) begin
					phase_d = PH_LEN;
					func_d  = rx_byte;
					sum_d   = sum_q + rx_byte;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (len_ok) begin
					phase_d  = PH_PAYLOAD;
					len_d    = rx_byte[5:0];
					rem_d    = rx_byte[5:0];
					stored_d = '0;
					sum_d    = sum_q + rx_byte;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				// zero length lands here with nothing left: next byte aborts
				if (rem_q != 6'd0) begin
					wr_en    = 1'b1;
					stored_d = stored_q + 6'd1;
					rem_d    = rem_q - 6'd1;
					sum_d    = sum_q + rx_byte;
					if (rem_q == 6'd1) begin
						phase_d = PH_CHECK;
					end
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CHECK: phase_d = PH_HUNT;
			default:  phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			rem_q    <= '0;
			stored_q <= '0;
			sum_q    <= '0;
			func_q   <= '0;
			len_q    <= '0;
		end else if (cmd.take_byte) begin
			phase_q  <= phase_d;
			rem_q    <= rem_d;
			stored_q <= stored_d;
			sum_q    <= sum_d;
			func_q   <= func_d;
			len_q    <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && wr_en) begin
			store_mem[stored_q[AW-1:0]] <= rx_byte;
		end
		rdata_q <= store_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.rd_clear) begin
			idx_q <= '0;
		end else if (cmd.load_pay) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_pay) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_status_q <= 1'b1;
			out_func_q   <= func_q;
			out_len_q    <= len_q;
			out_idx_q    <= '0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.load_pay) begin
			out_status_q <= 1'b0;
			out_func_q   <= func_q;
			out_len_q    <= len_q;
			out_idx_q    <= idx_q;
			out_byte_q   <= rdata_q;
			out_last_q   <= stat.idx_last;
		end
	end

	assign stat.at_check  = (phase_q == PH_CHECK);
	assign stat.sum_match = (sum_q == rx_byte);
	assign stat.slot_busy = out_valid_q && !frame.ready;
	assign stat.idx_last  = (6'(idx_q + 6'd1) == stored_q);

	assign frame.valid          = out_valid_q;
	assign frame.status         = out_status_q;
	assign frame.function_code  = out_func_q;
	assign frame.payload_length = out_len_q;
	assign frame.byte_index     = out_idx_q;
	assign frame.payload_byte   = out_byte_q;
	assign frame.last           = out_last_q;

endmodule

`default_nettype wire

### hdl/sync_frame_receiver_checksum_top.sv
// Sync frame receiver with additive checksum: top level, APB registers, assertions.
// Depends on sfrc_pkg, sfrc_if, sfrc_ctrl, sfrc_dp and the defines header.
//
// Usage:
//  - link: one received byte per beat (valid/ready). Frames are sync, sync,
//    function code, length, payload, checksum (8-bit sum of all earlier bytes).
//  - frame: result beats. A good frame yields one beat per payload byte, last
//    set on the final one; a bad checksum yields a single beat with status 1.
//  - APB: sync byte at 0x0, function limit at 0x4, length limit at 0x8.
//    Write only while idle. pready is tied high.
// Timing:
//  - Header and payload bytes: taken as they arrive, link ready stays high.
//  - Checksum byte: for a good frame the result run starts after a read state
//    and a load state; an error beat is loaded straight from the checksum byte.
//    Each payload beat is a read of the payload store, then a load of the output
//    register, held while the receiver stalls; link ready is low during the run.
//  - Results sit in an output register; new bytes are taken while it waits,
//    except the checksum byte, which holds until the register is free.
//  - Receiver stall holds the current beat and pauses the run.
// Reset: parser back to sync hunt, output empty, registers to 0xAA/241/50.
// The payload store is not cleared; entries are always written before read.
`default_nettype none

`include "sync_frame_receiver_checksum_top_defines.svh"

module sync_frame_receiver_checksum_top #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfrc_byte_if.sink        link,
	sfrc_result_if.source    frame,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfrc_pkg::*;

	// store never needs more than the 6-bit length allows
	localparam int STORE_DEPTH = (PAYLOAD_DEPTH < 64) ? PAYLOAD_DEPTH : 64;

	sfrc_cfg_t  cfg_q;
	sfrc_cmd_t  cmd;
	sfrc_stat_t stat;
	logic       reg_wr;

	// APB: register written on the access phase
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte      <= SYNC_BYTE_RST;
			cfg_q.function_limit <= FUNCTION_LIMIT_RST;
			cfg_q.length_limit   <= LENGTH_LIMIT_RST;
		end else if (reg_wr) begin
			case (paddr[3:2])
				REG_SYNC_BYTE:      cfg_q.sync_byte      <= pwdata[7:0];
				REG_FUNCTION_LIMIT: cfg_q.function_limit <= pwdata[8:0];
				REG_LENGTH_LIMIT:   cfg_q.length_limit   <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SYNC_BYTE:      prdata = {24'd0, cfg_q.sync_byte};
			REG_FUNCTION_LIMIT: prdata = {23'd0, cfg_q.function_limit};
			REG_LENGTH_LIMIT:   prdata = {25'd0, cfg_q.length_limit};
			default:            prdata = '0;
		endcase
	end

	sfrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link.valid),
		.in_ready (link.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfrc_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rx_byte (link.rx_byte),
		.cmd     (cmd),
		.stat    (stat),
		.frame   (frame)
	);

	// output register is never overwritten while a beat is held
	`SFRC_ASSERT_IMP(a_load_slot_free, clk, arst_n, cmd.load_err || cmd.load_pay, !stat.slot_busy)
	// no link byte is taken while a payload run is being emitted
	`SFRC_ASSERT_IMP(a_no_rx_in_run, clk, arst_n, cmd.load_pay, !link.ready)
	// a good checksum starts the run: intake closes on the next cycle
	`SFRC_ASSERT_NXT(a_run_closes_rx, clk, arst_n, cmd.rd_clear, !link.ready && !frame.valid || !link.ready)

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for sync_frame_receiver_checksum_top: a directed frame table, then random frames
// under four register settings, checked beat by beat against a built-in frame parser model.
// Depends on sfrc_pkg, sfrc_if and the RTL of the receiver.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfrc_pkg::*;

	localparam int PAYLOAD_DEPTH  = 64;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int REPORT_LINES   = 40;

	// paddr slot past the last register; writes there must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// one result beat as seen on the frame channel
	typedef struct packed {
		logic       status;
		logic [7:0] function_code;
		logic [5:0] payload_length;
		logic [5:0] byte_index;
		logic [7:0] payload_byte;
		logic       last;
	} frame_beat_t;

	// one link byte; typed rows carry a hand-written expected beat
	typedef struct packed {
		logic [7:0]  rx;
		logic        typed;
		frame_beat_t beat;
	} link_item_t;

	typedef enum {FR_GOOD, FR_BAD_SUM, FR_CUT} frame_kind_t;

	localparam frame_beat_t NO_BEAT = '0;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sfrc_byte_if   link_bus();
	sfrc_result_if frame_bus();

	sync_frame_receiver_checksum_top #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link_bus),
		.frame  (frame_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Directed frames, all under the reset settings (sync 0xAA, function
	// limit 241, length limit 50). Only the checksum rows of the short
	// frames have their beat typed in; the rest goes through the model.
	// ------------------------------------------------------------------
	link_item_t directed_rows [27] = '{
		// good frame, function 0, one payload byte 0xFF, sum 0x54
		'{8'hAA, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT},
		'{8'h01, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, NO_BEAT},
		'{8'h54, 1'b1, '{1'b0, 8'h00, 6'd1, 6'd0, 8'hFF, 1'b1}},
		// highest legal function code, bad checksum 0x00 (sum is 0xC6)
		'{8'hAA, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}, '{8'hF0, 1'b0, NO_BEAT},
		'{8'h02, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT}, '{8'h80, 1'b0, NO_BEAT},
		'{8'h00, 1'b1, '{1'b1, 8'hF0, 6'd2, 6'd0, 8'h00, 1'b1}},
		// second sync wrong: dropped, back to hunt
		'{8'hAA, 1'b0, NO_BEAT}, '{8'h55, 1'b0, NO_BEAT},
		// function code equal to its limit
		'{8'hAA, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}, '{8'hF1, 1'b0, NO_BEAT},
		// length equal to its limit
		'{8'hAA, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}, '{8'h00, 1'b0, NO_BEAT},
		'{8'h32, 1'b0, NO_BEAT},
		// zero length: the following sync byte aborts the frame and is lost
		'{8'hAA, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}, '{8'h10, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, NO_BEAT}, '{8'hAA, 1'b0, NO_BEAT}
	};

	// ------------------------------------------------------------------
	// Frame parser model: its own copy of the registers and parse state
	// ------------------------------------------------------------------
	logic [7:0]  cfg_sync;
	logic [8:0]  cfg_flimit;
	logic [6:0]  cfg_llimit;

	sfrc_phase_t parse_ph;
	logic [5:0]  left_cnt;
	logic [5:0]  stored_cnt;
	logic [7:0]  sum_acc;
	logic [7:0]  frame_fc;
	logic [5:0]  frame_len;
	logic [7:0]  pay_mem [PAYLOAD_DEPTH];

	frame_beat_t new_beats [$];   // beats caused by the latest byte
	frame_beat_t beats_due [$];   // beats still owed by the block
	link_item_t  tx_queue  [$];   // bytes waiting to go out on the link
	link_item_t  on_link;         // the byte currently offered on the link

	bit calm;                     // no idling on either side while set
	int mismatches;
	int queued_bytes;
	int link_beats;
	int result_beats;
	int error_beats;
	int settings_run;
	int idle_cycles;

	// the length limit is capped by the store and the 6-bit counters
	function automatic int eff_len_limit();
		int lim;
		lim = cfg_llimit;
		if (lim > PAYLOAD_DEPTH)
			lim = PAYLOAD_DEPTH;
		if (lim > 64)
			lim = 64;
		return lim;
	endfunction

	function automatic void push_beat(logic st, logic [5:0] idx, logic [7:0] val, logic lst);
		new_beats.push_back('{st, frame_fc, frame_len, idx, val, lst});
	endfunction

	function automatic void step_parser(logic [7:0] b);
		new_beats = {};
		case (parse_ph)
			PH_HUNT: begin
				if (b == cfg_sync) begin
					parse_ph = PH_SYNC2;
					sum_acc  = b;
				end
			end
			PH_SYNC2: begin
				if (b == cfg_sync) begin
					parse_ph = PH_FUNC;
					sum_acc  = sum_acc + b;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
			PH_FUNC: begin
				if ({1'b0, b} < cfg_flimit) begin
					parse_ph = PH_LEN;
					frame_fc = b;
					sum_acc  = sum_acc + b;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (int'(b) < eff_len_limit()) begin
					parse_ph   = PH_PAYLOAD;
					frame_len  = b[5:0];
					left_cnt   = b[5:0];
					stored_cnt = '0;
					sum_acc    = sum_acc + b;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				// zero length lands here with nothing left: abort
				if (left_cnt != 0) begin
					pay_mem[stored_cnt] = b;
					stored_cnt = stored_cnt + 6'd1;
					left_cnt   = left_cnt - 6'd1;
					sum_acc    = sum_acc + b;
					if (left_cnt == 0)
						parse_ph = PH_CHECK;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
			PH_CHECK: begin
				parse_ph = PH_HUNT;
				if (sum_acc != b) begin
					push_beat(1'b1, 6'd0, 8'h00, 1'b1);
				end else begin
					for (int i = 0; i < stored_cnt; i++)
						push_beat(1'b0, i[5:0], pay_mem[i], i + 1 == stored_cnt);
				end
			end
			default: begin
				parse_ph = PH_HUNT;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int n, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result beat %0d %s: got 0x%0h, want 0x%0h",
				n, name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Link source: offers queued bytes, idles at random unless calm
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && (!link_bus.valid || link_bus.ready)) begin
			if (tx_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
				link_bus.valid   <= 1'b1;
				link_bus.rx_byte <= tx_queue[0].rx;
				on_link          <= tx_queue.pop_front();
			end else begin
				link_bus.valid <= 1'b0;
			end
		end
	end

	// frame sink: stalls at random unless calm
	always @(posedge clk) begin
		frame_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
	end

	// accepted link beat: step the model, book what it owes
	always @(posedge clk) begin
		if (arst_n && link_bus.valid && link_bus.ready) begin
			link_beats++;
			step_parser(link_bus.rx_byte);
			if (on_link.typed)
				beats_due.push_back(on_link.beat);
			else
				foreach (new_beats[i])
					beats_due.push_back(new_beats[i]);
		end
	end

	// accepted result beat: compare with the oldest owed beat
	always @(posedge clk) begin : frame_check
		frame_beat_t got;
		frame_beat_t want;
		if (arst_n && frame_bus.valid && frame_bus.ready) begin
			got = {frame_bus.status, frame_bus.function_code, frame_bus.payload_length,
				frame_bus.byte_index, frame_bus.payload_byte, frame_bus.last};
			if (got.status)
				error_beats++;
			if (beats_due.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing owed: 0x%0h",
					result_beats, got));
			end else begin
				want = beats_due.pop_front();
				check_field("status", result_beats, 8'(got.status), 8'(want.status));
				check_field("function_code", result_beats, got.function_code,
					want.function_code);
				check_field("payload_length", result_beats, 8'(got.payload_length),
					8'(want.payload_length));
				check_field("byte_index", result_beats, 8'(got.byte_index),
					8'(want.byte_index));
				check_field("payload_byte", result_beats, got.payload_byte,
					want.payload_byte);
				check_field("last", result_beats, 8'(got.last), 8'(want.last));
			end
			result_beats++;
		end
	end

	// register writes seen on APB update the model's copy
	always @(posedge clk) begin
		if (arst_n && psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_SYNC_BYTE:      cfg_sync   <= pwdata[7:0];
				REG_FUNCTION_LIMIT: cfg_flimit <= pwdata[8:0];
				REG_LENGTH_LIMIT:   cfg_llimit <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// watchdog: too long without any accepted beat ends the run
	always @(posedge clk) begin
		if ((link_bus.valid && link_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// setup cycle, access cycle, then an idle wait so the model has the value
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// upper pwdata bits are junk on purpose; only the field width counts
	task automatic set_config(input logic [7:0] sync_v, input logic [8:0] flim_v,
			input logic [6:0] llim_v);
		apb_write(REG_SYNC_BYTE, ($urandom() & ~32'hFF) | sync_v);
		apb_write(REG_FUNCTION_LIMIT, ($urandom() & ~32'h1FF) | flim_v);
		apb_write(REG_LENGTH_LIMIT, ($urandom() & ~32'h7F) | llim_v);
		settings_run++;
	endtask

	// wait until the link is drained and every owed beat is back
	task automatic settle();
		while (tx_queue.size() != 0 || link_bus.valid || beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		tx_queue.push_back({b, 1'b0, NO_BEAT});
		queued_bytes++;
	endtask

	function automatic logic [7:0] pick_function();
		logic [8:0] top;
		top = cfg_flimit - 9'd1;
		if ($urandom_range(0, 9) == 0)
			return top[7:0];
		return 8'($urandom_range(0, top));
	endfunction

	// mostly short payloads; now and then zero or the longest legal
	function automatic int pick_length();
		int eff;
		int r;
		eff = eff_len_limit();
		if (eff <= 1)
			return 0;
		r = $urandom_range(0, 9);
		if (r == 0)
			return eff - 1;
		if (r == 1)
			return 0;
		return $urandom_range(1, (eff - 1 < 8) ? eff - 1 : 8);
	endfunction

	task automatic queue_frame(input frame_kind_t kind, input int len);
		logic [7:0] fb [$];
		logic [7:0] sum;
		int keep;
		fb = {};
		fb.push_back(cfg_sync);
		fb.push_back(cfg_sync);
		fb.push_back(pick_function());
		fb.push_back(len[7:0]);
		repeat (len) fb.push_back(8'($urandom_range(0, 255)));
		sum = '0;
		foreach (fb[i])
			sum = sum + fb[i];
		fb.push_back(kind == FR_BAD_SUM ? sum + 8'($urandom_range(1, 255)) : sum);
		// a cut frame stops early and is followed by one stray byte
		keep = (kind == FR_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
		for (int i = 0; i < keep; i++)
			queue_byte(fb[i]);
		if (kind == FR_CUT)
			queue_byte(8'($urandom_range(0, 255)));
	endtask

	// mix of good frames, bad sums, broken frames and plain noise
	task automatic queue_random(input int budget);
		int start;
		int pick;
		start = queued_bytes;
		while (queued_bytes - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				queue_frame(FR_GOOD, pick_length());
			else if (pick < 78)
				queue_frame(FR_BAD_SUM, pick_length());
			else if (pick < 90)
				queue_frame(FR_CUT, pick_length());
			else
				repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		link_bus.valid   = 1'b0;
		link_bus.rx_byte = '0;
		frame_bus.ready  = 1'b0;
		on_link          = '0;
		calm             = 1'b0;
		mismatches       = 0;
		queued_bytes     = 0;
		link_beats       = 0;
		result_beats     = 0;
		error_beats      = 0;
		settings_run     = 1;
		idle_cycles      = 0;
		// model at reset
		cfg_sync   = SYNC_BYTE_RST;
		cfg_flimit = FUNCTION_LIMIT_RST;
		cfg_llimit = LENGTH_LIMIT_RST;
		parse_ph   = PH_HUNT;
		left_cnt   = '0;
		stored_cnt = '0;
		sum_acc    = '0;
		frame_fc   = '0;
		frame_len  = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: directed table, then random traffic
		foreach (directed_rows[i])
			tx_queue.push_back(directed_rows[i]);
		settle();
		queue_random(25);
		settle();

		// sync 0x00, every function code legal, longest frames the store takes;
		// the first longest frame runs with no idling, the second under stalls
		set_config(8'h00, 9'd256, 7'd64);
		calm = 1'b1;
		queue_random(10);
		queue_frame(FR_GOOD, eff_len_limit() - 1);
		settle();
		calm = 1'b0;
		queue_frame(FR_GOOD, eff_len_limit() - 1);
		queue_random(10);
		settle();

		// tightest limits: only function 0 and length 0, so every frame aborts
		set_config(8'hFF, 9'd1, 7'd1);
		queue_random(10);
		settle();

		// random sync and function limit, length limit far beyond the store;
		// a write to the unused slot must change nothing
		set_config(8'($urandom_range(0, 255)), 9'($urandom_range(2, 255)), 7'd127);
		apb_write(REG_UNUSED, $urandom());
		queue_random(20);
		settle();

		$display("Sent %0d link bytes; got %0d result beats, %0d of them checksum errors.",
			link_beats, result_beats, error_beats);
		$display("Covered %0d register settings, with and without idling on both channels.",
			settings_run);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
